>>> hw/rtl/bbr_pkg.sv
// bbr_pkg: shared types, constants and the mean function of the 3x3 box blur
// used by bbr_cell, box_blur_3x3_rgb and bbr_checker; depends on nothing

package bbr_pkg;

  // default line store depth and register reset values
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int FrameWidthRst   = 640;
  localparam int FrameHeightRst  = 480;
  localparam int CfgDataWidth    = 16;
  localparam int RowCntWidth     = 17;

  // register indexes of the config port
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_e;

  // neighbor count of one output pixel
  typedef enum logic [1:0] {
    N4 = 2'd0,
    N6 = 2'd1,
    N9 = 2'd2
  } ncode_e;

  // one rgb pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // one window column: index 0 top, 1 middle, 2 bottom
  typedef pix_t [2:0] col_t;

  // masked column sum per channel
  typedef struct packed {
    logic [9:0] red;
    logic [9:0] green;
    logic [9:0] blue;
  } csum_t;

  // which outer rows of the window lie inside the frame
  typedef struct packed {
    logic top;
    logic bot;
  } rows_t;

  // per item control that travels down the pipeline
  typedef struct packed {
    logic   last;
    logic   col0;
    logic   col2;
    rows_t  rows;
    ncode_e ncode;
  } emit_ctrl_t;

  // neighbor count as a number
  function automatic logic [3:0] nval(ncode_e nc);
    logic [3:0] n;
    unique case (nc)
      N4:      n = 4'd4;
      N6:      n = 4'd6;
      N9:      n = 4'd9;
      default: n = 4'd4;
    endcase
    return n;
  endfunction

  // floor(num / (2n)) with num = 2*sum + n; reciprocal multiply for 12 and 18
  function automatic logic [7:0] mean8(logic [12:0] num, ncode_e nc);
    logic [21:0] p6;
    logic [22:0] p9;
    logic [7:0]  q;
    p6 = 22'(num[12:2]) * 22'(683);
    p9 = 23'(num[12:1]) * 23'(1821);
    unique case (nc)
      N4:      q = num[10:3];
      N6:      q = p6[18:11];
      N9:      q = p9[21:14];
      default: q = '0;
    endcase
    return q;
  endfunction

endpackage

>>> hw/rtl/bbr_ram.sv
// bbr_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module bbr_ram #(
  parameter int Width = 48,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bbr_cell.sv
// bbr_cell: one window column of the blur, shifts to its neighbor and sums its rows
// depends on bbr_pkg

module bbr_cell (
  input  logic           clk_i,
  input  logic           shift_i,
  input  bbr_pkg::col_t  col_i,
  input  bbr_pkg::rows_t rows_i,
  output bbr_pkg::col_t  col_o,
  output bbr_pkg::csum_t sum_o
);

  bbr_pkg::col_t col_q;

  // take the column handed over by the neighbor
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

  // column sum per channel, outer rows masked at the frame border
  always_comb begin
    sum_o.red   = 10'(col_q[1].red)
                + (rows_i.top ? 10'(col_q[0].red) : 10'd0)
                + (rows_i.bot ? 10'(col_q[2].red) : 10'd0);
    sum_o.green = 10'(col_q[1].green)
                + (rows_i.top ? 10'(col_q[0].green) : 10'd0)
                + (rows_i.bot ? 10'(col_q[2].green) : 10'd0);
    sum_o.blue  = 10'(col_q[1].blue)
                + (rows_i.top ? 10'(col_q[0].blue) : 10'd0)
                + (rows_i.bot ? 10'(col_q[2].blue) : 10'd0);
  end

endmodule

>>> hw/rtl/box_blur_3x3_rgb.sv
// box_blur_3x3_rgb: streaming 3x3 box blur of an rgb frame, top level
// depends on bbr_pkg, bbr_ram, bbr_cell
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata red,green,blue; tuser cmd
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata blur rgb; tlast frame_end
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// one item per cycle while the output skid is empty; a result leaves after the item
// that completes it passes the line store read, the window shift, the sum stage and the mean stage
// the pixel at raster index q comes out with the item at q + frame_width + 1
// rst_ni clears counters and handshake state; line stores and window are not cleared
// s_axis_tready drops only while the output skid holds a beat

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input pixels
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic        s_axis_tuser,   // cmd: 0 pixel, 1 flush
  // blurred pixels
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // blur_red [7:0], blur_green [15:8], blur_blue [23:16]
  output logic        m_axis_tlast,   // frame_end
  // config writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [bbr_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW  = ((AW > 11) ? AW : 11) + 1;
  localparam int RW  = bbr_pkg::RowCntWidth;
  localparam int WLastRst =
    ((bbr_pkg::FrameWidthRst > MAX_WIDTH) ? MAX_WIDTH : bbr_pkg::FrameWidthRst) - 1;

  // config registers, held as last column and last row
  logic [AW-1:0] wlast_q, wlast_d;
  logic [15:0]   hlast_q, hlast_d;
  logic [LW-1:0] fw_ext;
  logic [15:0]   fh;
  logic          cfg_fire;

  // position counters
  logic [AW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d;
  logic [15:0]   out_row_q, out_row_d;

  // accept stage
  logic               s_fire, drain, take, emit_a, emit_b, emit, last_hit;
  logic               en;
  bbr_pkg::emit_ctrl_t ctrl0;
  bbr_pkg::pix_t       pix0;

  // pipeline registers
  logic                s1_valid_q, s1_emit_q, s2_emit_q, s3_emit_q;
  logic [AW-1:0]       s1_addr_q;
  bbr_pkg::pix_t       s1_pix_q;
  bbr_pkg::emit_ctrl_t s1_ctrl_q, s2_ctrl_q;
  logic [12:0]         s3_num_r_q, s3_num_g_q, s3_num_b_q;
  logic                s3_last_q;
  bbr_pkg::ncode_e     s3_ncode_q;

  // line store and window
  logic [47:0]    ram_rdata;
  bbr_pkg::col_t  new_col;
  bbr_pkg::col_t  col2_o, col1_o, col0_o;
  bbr_pkg::csum_t sum0, sum1, sum2;
  logic           shift;
  logic [11:0]    sum_r, sum_g, sum_b;
  logic [3:0]     nnum;

  // output register and skid
  logic [23:0] res_data;
  logic [23:0] out_data_q, skid_data_q;
  logic        out_last_q, skid_last_q, out_valid_q, skid_valid_q, out_take;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  // clamp written frame size
  assign fw_ext = LW'(cfg_data_i[10:0]);
  assign fh     = cfg_data_i[15:0];

  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_fire) begin
      unique case (bbr_pkg::reg_e'(cfg_index_i))
        bbr_pkg::REG_FRAME_WIDTH: begin
          if (fw_ext < LW'(2)) begin
            wlast_d = AW'(1);
          end else if (fw_ext > LW'(MAX_WIDTH)) begin
            wlast_d = AW'(MAX_WIDTH - 1);
          end else begin
            wlast_d = AW'(fw_ext - LW'(1));
          end
        end
        bbr_pkg::REG_FRAME_HEIGHT: begin
          hlast_d = (fh < 16'd2) ? 16'd1 : fh - 16'd1;
        end
      endcase
    end
  end

  // pipeline moves whenever the skid is empty
  assign en            = ~skid_valid_q;
  assign s_axis_tready = en;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  // accept stage decisions
  assign drain    = in_row_q > {1'b0, hlast_q};
  assign take     = s_fire & (drain | ~s_axis_tuser);
  assign emit_a   = (in_col_q == '0) & (|in_row_q[RW-1:1]);
  assign emit_b   = (in_col_q != '0) & (in_row_q != '0);
  assign emit     = emit_a | emit_b;
  assign last_hit = emit & (out_row_q == hlast_q) & (out_col_q == wlast_q);
  assign pix0     = drain ? '0 : bbr_pkg::pix_t'({s_axis_tdata[7:0], s_axis_tdata[15:8],
                                                  s_axis_tdata[23:16]});

  always_comb begin
    ctrl0.last     = last_hit;
    ctrl0.col0     = out_col_q != '0;
    ctrl0.col2     = ~emit_a;
    ctrl0.rows.top = out_row_q != '0;
    ctrl0.rows.bot = out_row_q < hlast_q;
    if (ctrl0.col0 & ctrl0.col2 & ctrl0.rows.top & ctrl0.rows.bot) begin
      ctrl0.ncode = bbr_pkg::N9;
    end else if ((ctrl0.col0 & ctrl0.col2) | (ctrl0.rows.top & ctrl0.rows.bot)) begin
      ctrl0.ncode = bbr_pkg::N6;
    end else begin
      ctrl0.ncode = bbr_pkg::N4;
    end
  end

  // counter updates
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_fire || (take && last_hit)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (take) begin
      if (in_col_q == wlast_q) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + AW'(1);
      end
      if (emit) begin
        if (out_col_q == wlast_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + 16'd1;
        end else begin
          out_col_d = out_col_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q   <= AW'(WLastRst);
      hlast_q   <= 16'(bbr_pkg::FrameHeightRst - 1);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      wlast_q   <= wlast_d;
      hlast_q   <= hlast_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // two rows per entry: older in the upper half, newer in the lower half
  bbr_ram #(
    .Width (48),
    .Depth (MAX_WIDTH)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q & en),
    .waddr_i (s1_addr_q),
    .wdata_i ({ram_rdata[23:0], s1_pix_q}),
    .re_i    (take),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  // window: new column enters cell 2 and walks down to cell 0
  assign shift      = s1_valid_q & en;
  assign new_col[0] = bbr_pkg::pix_t'(ram_rdata[47:24]);
  assign new_col[1] = bbr_pkg::pix_t'(ram_rdata[23:0]);
  assign new_col[2] = s1_pix_q;

  bbr_cell u_cell2 (
    .clk_i   (clk_i),
    .shift_i (shift),
    .col_i   (new_col),
    .rows_i  (s2_ctrl_q.rows),
    .col_o   (col2_o),
    .sum_o   (sum2)
  );

  bbr_cell u_cell1 (
    .clk_i   (clk_i),
    .shift_i (shift),
    .col_i   (col2_o),
    .rows_i  (s2_ctrl_q.rows),
    .col_o   (col1_o),
    .sum_o   (sum1)
  );

  bbr_cell u_cell0 (
    .clk_i   (clk_i),
    .shift_i (shift),
    .col_i   (col1_o),
    .rows_i  (s2_ctrl_q.rows),
    .col_o   (col0_o),
    .sum_o   (sum0)
  );

  // window sum with border columns masked
  always_comb begin
    sum_r = 12'(sum1.red)   + (s2_ctrl_q.col0 ? 12'(sum0.red)   : 12'd0)
          + (s2_ctrl_q.col2 ? 12'(sum2.red)   : 12'd0);
    sum_g = 12'(sum1.green) + (s2_ctrl_q.col0 ? 12'(sum0.green) : 12'd0)
          + (s2_ctrl_q.col2 ? 12'(sum2.green) : 12'd0);
    sum_b = 12'(sum1.blue)  + (s2_ctrl_q.col0 ? 12'(sum0.blue)  : 12'd0)
          + (s2_ctrl_q.col2 ? 12'(sum2.blue)  : 12'd0);
    nnum  = bbr_pkg::nval(s2_ctrl_q.ncode);
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
      s2_emit_q  <= 1'b0;
      s3_emit_q  <= 1'b0;
    end else if (en) begin
      s1_valid_q <= take;
      s1_emit_q  <= take & emit;
      s2_emit_q  <= s1_emit_q;
      s3_emit_q  <= s2_emit_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_addr_q  <= in_col_q;
      s1_pix_q   <= pix0;
      s1_ctrl_q  <= ctrl0;
      s2_ctrl_q  <= s1_ctrl_q;
      s3_num_r_q <= {sum_r, 1'b0} + 13'(nnum);
      s3_num_g_q <= {sum_g, 1'b0} + 13'(nnum);
      s3_num_b_q <= {sum_b, 1'b0} + 13'(nnum);
      s3_last_q  <= s2_ctrl_q.last;
      s3_ncode_q <= s2_ctrl_q.ncode;
    end
  end

  // rounded means
  assign res_data = {bbr_pkg::mean8(s3_num_b_q, s3_ncode_q),
                     bbr_pkg::mean8(s3_num_g_q, s3_ncode_q),
                     bbr_pkg::mean8(s3_num_r_q, s3_ncode_q)};

  // output register with one skid beat
  assign out_take = out_valid_q & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (s3_emit_q) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_data_q <= skid_data_q;
        out_last_q <= skid_last_q;
      end
    end else if (s3_emit_q) begin
      if (out_valid_q && !out_take) begin
        skid_data_q <= res_data;
        skid_last_q <= s3_last_q;
      end else begin
        out_data_q <= res_data;
        out_last_q <= s3_last_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> hw/rtl/bbr_checker.sv
// bbr_checker: port level checks of box_blur_3x3_rgb, bound to the top level
// depends on box_blur_3x3_rgb ports and bbr_pkg

module bbr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [23:0]                      s_axis_tdata,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [23:0]                      m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic                             cfg_index_i,
  input logic [bbr_pkg::CfgDataWidth-1:0] cfg_data_i
);

  // a stalled output beat stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // input side only backs up behind a held output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output pending");

  // input side stalls only after an output beat was refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back pressure");

endmodule

bind box_blur_3x3_rgb bbr_checker u_bbr_checker (.*);

>>> dv/tb.sv
// tb: self-checking testbench of box_blur_3x3_rgb, predicts every blurred beat
// in a scoreboard class and drives pixel, result and register channels
// depends on bbr_pkg and box_blur_3x3_rgb
`timescale 1ns / 1ps

module tb;
  import bbr_pkg::*;

  localparam int  LINE_DEPTH  = MAX_WIDTH_DEF;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  PRINT_LIMIT = 40;
  localparam int  LAT_CYCLES  = 8;
  localparam bit  CMD_PIXEL   = 1'b0;
  localparam bit  CMD_FLUSH   = 1'b1;

  // one expected output beat
  typedef struct packed {
    pix_t blur;
    logic frame_end;
  } blur_t;

  // blur prediction and result checking
  class blur_scoreboard;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    pix_t        older_row[LINE_DEPTH];
    pix_t        newer_row[LINE_DEPTH];
    pix_t        win[9];
    int          in_col, in_row, out_col, out_row;
    blur_t       pending_blurs[$];
    int          errors;
    int          beats;

    function new();
      width_reg  = 11'(FrameWidthRst);
      height_reg = 16'(FrameHeightRst);
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      errors = 0;
      beats  = 0;
      restart();
    endfunction

    function void restart();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function int used_w();
      int w;
      w = int'(width_reg);
      if (w < 2) w = 2;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
    endfunction

    function int used_h();
      int h;
      h = int'(height_reg);
      if (h < 2) h = 2;
      return h;
    endfunction

    function int pending();
      return pending_blurs.size();
    endfunction

    // register write, every write restarts the frame
    function void apply_reg(reg_e idx, logic [15:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val[10:0];
      else height_reg = val;
      restart();
    endfunction

    // blur of the pixel at the output position, centered on window column k
    function bit blur_at(int k, int w, int h);
      int    r0, r1, c0, c1, n, sr, sg, sbl;
      blur_t e;
      r0 = (out_row >= 1) ? 0 : 1;
      r1 = (out_row + 1 < h) ? 2 : 1;
      c0 = (out_col >= 1) ? k - 1 : k;
      c1 = (out_col + 1 < w && k < 2) ? k + 1 : k;
      n  = (r1 - r0 + 1) * (c1 - c0 + 1);
      sr = 0;
      sg = 0;
      sbl = 0;
      for (int i = r0; i <= r1; i++) begin
        for (int j = c0; j <= c1; j++) begin
          sr  += int'(win[i*3+j].red);
          sg  += int'(win[i*3+j].green);
          sbl += int'(win[i*3+j].blue);
        end
      end
      // round half up
      e.blur.red   = 8'((2 * sr + n) / (2 * n));
      e.blur.green = 8'((2 * sg + n) / (2 * n));
      e.blur.blue  = 8'((2 * sbl + n) / (2 * n));
      e.frame_end  = (out_row == h - 1) && (out_col == w - 1);
      pending_blurs.push_back(e);
      if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
      return e.frame_end;
    endfunction

    // accepted input beat: update line stores and window, queue blurs
    function void note_item(bit cmd, pix_t px);
      int   w, h, x;
      pix_t top, mid, p;
      w = used_w();
      h = used_h();
      p = px;
      x = in_col;
      // flush before the frame is complete is ignored
      if (in_row < h && cmd == CMD_FLUSH) return;
      // pixel while draining acts as a flush
      if (in_row >= h) p = '0;
      if (x >= w) x = 0;
      // row start finishes the last pixel of the row two above
      if (x == 0 && in_row >= 2) begin
        if (blur_at(2, w, h)) begin
          restart();
          return;
        end
      end
      top = older_row[x];
      mid = newer_row[x];
      older_row[x] = mid;
      newer_row[x] = p;
      for (int i = 0; i < 3; i++) begin
        win[i*3]   = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = p;
      if (x >= 1 && in_row >= 1) begin
        if (blur_at(1, w, h)) begin
          restart();
          return;
        end
      end
      if (x + 1 >= w) begin
        in_col = 0;
        in_row++;
      end else begin
        in_col = x + 1;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("tb: mismatch: %s", msg);
    endtask

    // accepted output beat against the oldest expected blur
    task check_result(pix_t got, logic last);
      blur_t want;
      beats++;
      if (pending_blurs.size() == 0) begin
        report($sformatf("beat %0d arrived with no blur expected", beats));
        return;
      end
      want = pending_blurs.pop_front();
      if (got.red !== want.blur.red)
        report($sformatf("beat %0d red %0h want %0h", beats, got.red, want.blur.red));
      if (got.green !== want.blur.green)
        report($sformatf("beat %0d green %0h want %0h", beats, got.green, want.blur.green));
      if (got.blue !== want.blur.blue)
        report($sformatf("beat %0d blue %0h want %0h", beats, got.blue, want.blur.blue));
      if (last !== want.frame_end)
        report($sformatf("beat %0d frame_end %b want %b", beats, last, want.frame_end));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i   = 1'b0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  blur_scoreboard blurs = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int items_counted  = 0;
  int cur_w          = FrameWidthRst;
  int cur_h          = FrameHeightRst;

  box_blur_3x3_rgb #(
    .MAX_WIDTH(LINE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // random backpressure on the result side
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watch all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) blurs.apply_reg(reg_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid && s_axis_tready)
        blurs.note_item(s_axis_tuser,
                        {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]});
      if (m_axis_tvalid && m_axis_tready)
        blurs.check_result({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]},
                           m_axis_tlast);
    end
  end

  function automatic logic [7:0] any_channel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_t any_pixel();
    return {any_channel(), any_channel(), any_channel()};
  endfunction

  // register codes that land on the wanted size after masking and clamping
  function automatic logic [15:0] width_code(int w);
    logic [15:0] v;
    v = 16'(w);
    if (w == 2 && $urandom_range(2) == 0) v = 16'($urandom_range(1));
    if ($urandom_range(3) == 0) v[15:11] = 5'($urandom);
    return v;
  endfunction

  function automatic logic [15:0] height_code(int h);
    logic [15:0] v;
    v = 16'(h);
    if (h == 2 && $urandom_range(2) == 0) v = 16'($urandom_range(1));
    return v;
  endfunction

  // one input beat, with a random idle gap in front
  task automatic send_item(input bit cmd, input pix_t px);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {px.blue, px.green, px.red};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending until every expected blur has come out
  task automatic hold_until_drained(input int extra);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (blurs.pending() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_reg(input reg_e idx, input logic [15:0] val);
    hold_until_drained(LAT_CYCLES);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_size(input int w, input int h, input bit must_write);
    bit wrote;
    wrote = 1'b0;
    if (w != cur_w || (must_write && $urandom_range(1) == 1)) begin
      write_reg(REG_FRAME_WIDTH, width_code(w));
      wrote = 1'b1;
    end
    if (h != cur_h || (must_write && !wrote)) write_reg(REG_FRAME_HEIGHT, height_code(h));
    cur_w = w;
    cur_h = h;
  endtask

  // a well-formed frame with drain, or a broken one cut short
  task automatic random_frame(input bit broken, input bit pause, input int cap);
    int wh, total, pause_at;
    wh = cur_w * cur_h;
    total = broken ? $urandom_range(1, wh + cur_w) : wh + cur_w + 1;
    if (total > cap) total = cap;
    pause_at = pause ? $urandom_range(0, total - 1) : -1;
    for (int i = 0; i < total; i++) begin
      if (i == pause_at) hold_until_drained(0);
      if (i < wh) begin
        // stray flush inside the frame
        if ($urandom_range(19) == 0) send_item(CMD_FLUSH, any_pixel());
        send_item(CMD_PIXEL, any_pixel());
      end else begin
        send_item($urandom_range(1) ? CMD_FLUSH : CMD_PIXEL, any_pixel());
      end
      items_counted++;
    end
  endtask

  initial begin
    int  w, h, target;
    bit  broken, need_restart, first;
    pix_t px;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 2x2 frame, widths and heights below the floor
    write_reg(REG_FRAME_WIDTH, 16'd1);
    write_reg(REG_FRAME_HEIGHT, 16'd0);
    cur_w = 2;
    cur_h = 2;
    send_item(CMD_FLUSH, 24'hffffff);
    send_item(CMD_PIXEL, {8'hff, 8'hff, 8'hff});
    send_item(CMD_FLUSH, 24'h000000);
    send_item(CMD_PIXEL, {8'hff, 8'h00, 8'h80});
    send_item(CMD_PIXEL, {8'h00, 8'hff, 8'h01});
    send_item(CMD_PIXEL, {8'h00, 8'h00, 8'h00});
    send_item(CMD_PIXEL, {8'hff, 8'hff, 8'hff});
    send_item(CMD_FLUSH, 24'hffffff);
    send_item(CMD_PIXEL, {8'h55, 8'haa, 8'hff});

    // 3x3 frame: corners, edges and the center
    write_reg(REG_FRAME_WIDTH, 16'd3);
    write_reg(REG_FRAME_HEIGHT, 16'd3);
    cur_w = 3;
    cur_h = 3;
    for (int q = 0; q < 9; q++) begin
      px = (q % 2 == 1) ? 24'hffffff : {8'(q * 31), 8'hff - 8'(q * 17), 8'h00};
      send_item(CMD_PIXEL, px);
    end
    for (int q = 0; q < 4; q++) send_item((q % 2 == 1) ? CMD_PIXEL : CMD_FLUSH, 24'hffffff);

    // random frames under four idling patterns
    need_restart = 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      target = items_counted + 175;
      first  = 1'b1;
      while (items_counted < target) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(10, 32) : $urandom_range(2, 9);
        h = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(2, 6);
        if (!need_restart && $urandom_range(3) == 0) begin
          w = cur_w;
          h = cur_h;
        end
        set_size(w, h, need_restart);
        broken = ($urandom_range(4) == 0);
        random_frame(broken, first || $urandom_range(5) == 0, 1 << 30);
        need_restart = broken;
        first = 1'b0;
      end
    end

    // widest line, written above the maximum
    write_reg(REG_FRAME_WIDTH, 16'd2047);
    write_reg(REG_FRAME_HEIGHT, 16'd2);
    cur_w = LINE_DEPTH;
    cur_h = 2;
    random_frame(1'b0, 1'b1, 40);

    // tallest frame, cut short; width upper bits masked off
    write_reg(REG_FRAME_WIDTH, 16'hf802);
    write_reg(REG_FRAME_HEIGHT, 16'hffff);
    cur_w = 2;
    cur_h = 65535;
    random_frame(1'b1, 1'b0, 40);

    hold_until_drained(20);
    if (blurs.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bbr_pkg.sv
hw/rtl/bbr_ram.sv
hw/rtl/bbr_cell.sv
hw/rtl/box_blur_3x3_rgb.sv
hw/rtl/bbr_checker.sv
dv/tb.sv
